@@ src/cqfs_pkg.sv @@
// ----------------------------------------------------------------------------
// Circle quadrant fill spans: shared definitions
// Field widths, quadrant bit positions and iteration constants.
// ----------------------------------------------------------------------------
package cqfs_pkg;

   localparam int RADIUS_WIDTH   = 7;
   localparam int QUADRANT_WIDTH = 2;
   localparam int RESULT_LIMIT   = 64;
   localparam int COUNT_WIDTH    = $clog2(RESULT_LIMIT);

   localparam int QUAD_RIGHT_BIT = 0;
   localparam int QUAD_DOWN_BIT  = 1;

   localparam int D_START      = 3;
   localparam int D_STEP_INNER = 6;
   localparam int D_STEP_OUTER = 10;

   typedef logic [RADIUS_WIDTH-1:0]   radius_type;
   typedef logic [QUADRANT_WIDTH-1:0] quadrant_type;

endpackage

@@ src/circle_quadrant_fill_spans.sv @@
// ----------------------------------------------------------------------------
// Circle quadrant fill spans
// Walks the Bresenham circle decision loop and emits two horizontal spans
// per step, reaching from the centre column out into one quadrant.
// ----------------------------------------------------------------------------
// A request on the req_ channel carries the centre, the radius and, in
// req_tuser, the quadrant. A radius above MAX_RADIUS is treated as MAX_RADIUS.
// The block then steps one shared adder datapath once per cycle and produces
// one result per step on the rsp_ channel: six span coordinates in rsp_tdata,
// with rsp_tlast high on the final result of the circle.
// A radius r gives about r/sqrt(2) + 1 results, 61 at a radius of 85, and
// never more than 64. The run state is registered from the request transfer,
// then results enter the output register one per cycle while the receiver
// takes them; the single loop register set (x, y, d) limits the block to one
// request at a time, and req_tready is low until the last result has been
// loaded into the output register.
// When the receiver stalls, the result is held in the output register and the
// loop waits. Reset returns the block to idle and drops any pending result.
// ----------------------------------------------------------------------------
module circle_quadrant_fill_spans
   import cqfs_pkg::*;
#(
   parameter int MAX_RADIUS  = 85,
   parameter int COORD_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,

   input  logic req_tvalid,
   output logic req_tready,
   // center_x, center_y, radius, zero padding
   input  logic [((2*COORD_WIDTH+RADIUS_WIDTH+7)/8)*8-1:0] req_tdata,
   // quadrant
   input  logic [QUADRANT_WIDTH-1:0] req_tuser,

   output logic rsp_tvalid,
   input  logic rsp_tready,
   // span_a_row, span_a_start, span_a_end, span_b_row, span_b_start,
   // span_b_end, zero padding
   output logic [((6*(COORD_WIDTH+1)+7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tlast
);

   localparam int OW      = COORD_WIDTH + 1;
   localparam int RSP_W   = ((6*OW+7)/8)*8;
   localparam int XYW     = $clog2(MAX_RADIUS+2) + 1;
   localparam int DW      = $clog2(MAX_RADIUS+1) + 5;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff, state_in;

   logic signed [COORD_WIDTH-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic                          right_ff, right_in, down_ff, down_in;
   logic signed [XYW-1:0]         x_ff, x_in, y_ff, y_in;
   logic signed [DW-1:0]          d_ff, d_in;
   logic [COUNT_WIDTH-1:0]        n_ff, n_in;

   logic                          valid_ff, valid_in;
   logic                          last_ff, last_in;
   logic signed [OW-1:0]          a_row_ff, a_row_in, a_start_ff, a_start_in;
   logic signed [OW-1:0]          a_end_ff, a_end_in, b_row_ff, b_row_in;
   logic signed [OW-1:0]          b_start_ff, b_start_in, b_end_ff, b_end_in;

   radius_type                    r_raw, r_sat;
   logic                          req_fire, load;
   logic signed [XYW-1:0]         x_nx, y_nx;
   logic signed [DW-1:0]          d_nx, x_d, y_d;
   logic signed [OW-1:0]          cx_o, cy_o, x_o, y_o;
   logic                          last_nx;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign load       = (state_ff == ST_RUN) && (!valid_ff || rsp_tready);

   assign r_raw = req_tdata[2*COORD_WIDTH +: RADIUS_WIDTH];
   assign r_sat = (r_raw > RADIUS_WIDTH'(MAX_RADIUS)) ? RADIUS_WIDTH'(MAX_RADIUS) : r_raw;

   // Shared step datapath: decision update, next point and span ends.
   always_comb begin
      x_d  = DW'(x_ff);
      y_d  = DW'(y_ff);
      x_nx = x_ff + signed'(XYW'(1));
      if (d_ff < 0) begin
         d_nx = d_ff + (x_d <<< 2) + signed'(DW'(D_STEP_INNER));
         y_nx = y_ff;
      end else begin
         d_nx = d_ff + ((x_d - y_d) <<< 2) + signed'(DW'(D_STEP_OUTER));
         y_nx = y_ff - signed'(XYW'(1));
      end
      last_nx = (y_nx < x_nx) || (n_ff == COUNT_WIDTH'(RESULT_LIMIT-1));

      cx_o = OW'(cx_ff);
      cy_o = OW'(cy_ff);
      x_o  = OW'(x_ff);
      y_o  = OW'(y_ff);
      a_row_in = down_ff ? cy_o + y_o : cy_o - y_o;
      b_row_in = down_ff ? cy_o + x_o : cy_o - x_o;
      if (right_ff) begin
         a_start_in = cx_o;
         a_end_in   = cx_o + x_o;
         b_start_in = cx_o;
         b_end_in   = cx_o + y_o;
      end else begin
         a_start_in = cx_o - x_o;
         a_end_in   = cx_o;
         b_start_in = cx_o - y_o;
         b_end_in   = cx_o;
      end
   end

   always_comb begin
      state_in = state_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      right_in = right_ff;
      down_in  = down_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      d_in     = d_ff;
      n_in     = n_ff;
      valid_in = valid_ff && !rsp_tready;
      last_in  = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_RUN;
               cx_in    = req_tdata[COORD_WIDTH-1:0];
               cy_in    = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
               right_in = req_tuser[QUAD_RIGHT_BIT];
               down_in  = req_tuser[QUAD_DOWN_BIT];
               x_in     = '0;
               y_in     = signed'(XYW'(r_sat));
               d_in     = signed'(DW'(D_START)) - (signed'(DW'(r_sat)) <<< 1);
               n_in     = '0;
            end
         end
         ST_RUN: begin
            if (load) begin
               valid_in = 1'b1;
               last_in  = last_nx;
               x_in     = x_nx;
               y_in     = y_nx;
               d_in     = d_nx;
               n_in     = n_ff + COUNT_WIDTH'(1);
               if (last_nx) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      right_ff <= right_in;
      down_ff  <= down_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      d_ff     <= d_in;
      n_ff     <= n_in;
      last_ff  <= last_in;
      if (load) begin
         a_row_ff   <= a_row_in;
         a_start_ff <= a_start_in;
         a_end_ff   <= a_end_in;
         b_row_ff   <= b_row_in;
         b_start_ff <= b_start_in;
         b_end_ff   <= b_end_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = RSP_W'({b_end_ff, b_start_ff, b_row_ff,
                               a_end_ff, a_start_ff, a_row_ff});

   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_RUN) && (x_ff == '0) && (n_ff == '0))
      else $error("Loop not started after a request transfer.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (x_ff <= y_ff))
      else $error("Loop running past the diagonal.");

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && last_ff && (state_ff == ST_RUN)) |-> (n_ff == '0))
      else $error("Final result pending while the next circle is stepping.");

endmodule

@@ sim/tb_circle_quadrant_fill_spans.sv @@
// ----------------------------------------------------------------------------
// Testbench for the circle quadrant fill spans block
// Sends fill requests with random and extreme centres, radii and quadrants,
// stalls both channels in random bursts, and compares every span pair
// field by field with a local model of the midpoint circle walk.
// ----------------------------------------------------------------------------
module tb_circle_quadrant_fill_spans;
   timeunit 1ns;
   timeprecision 1ps;
   import cqfs_pkg::*;

   localparam int MAX_RADIUS      = 85;
   localparam int COORD_WIDTH     = 16;
   localparam int SPAN_W          = COORD_WIDTH + 1;
   localparam int REQ_W           = ((2*COORD_WIDTH+RADIUS_WIDTH+7)/8)*8;
   localparam int RSP_W           = ((6*SPAN_W+7)/8)*8;
   localparam int RANDOM_REQUESTS = 440;
   localparam int CALM_REQUESTS   = 40;
   localparam int WATCHDOG_LIMIT  = 400;
   localparam int TAIL_CYCLES     = 16;
   localparam int REPORT_LIMIT    = 10;

   typedef enum logic [QUADRANT_WIDTH-1:0] {
      QUAD_LEFT_UP, QUAD_RIGHT_UP, QUAD_LEFT_DOWN, QUAD_RIGHT_DOWN
   } quad_code_type;

   typedef enum int {
      SPAN_A_ROW, SPAN_A_START, SPAN_A_END, SPAN_B_ROW, SPAN_B_START, SPAN_B_END,
      SPAN_FIELDS
   } span_field_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] center_x;
      logic signed [COORD_WIDTH-1:0] center_y;
      radius_type                    radius;
      quad_code_type                 quadrant;
      logic                          drain_first;
      logic                          calm_tail;
   } fill_req_type;

   typedef struct packed {
      logic                    last;
      logic [5:0][SPAN_W-1:0]  coord;
   } span_pair_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_tvalid  = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata   = '0;
   logic [QUADRANT_WIDTH-1:0] req_tuser = '0;
   logic             rsp_tvalid;
   logic             rsp_tready  = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;

   fill_req_type  pending_requests[$];
   span_pair_type expected_spans[$];
   fill_req_type  req_item;
   logic       req_taken   = 1'b0;
   logic       quiet_tail  = 1'b0;
   int         mismatches  = 0;
   int         quiet_cycles = 0;

   circle_quadrant_fill_spans #(
      .MAX_RADIUS (MAX_RADIUS),
      .COORD_WIDTH(COORD_WIDTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void predict_quadrant_spans(input fill_req_type rq);
      int            cx, cy, rad, x, y, d, n;
      logic          right, down;
      span_pair_type sp;
      cx    = int'(rq.center_x);
      cy    = int'(rq.center_y);
      rad   = int'(rq.radius);
      right = rq.quadrant[QUAD_RIGHT_BIT];
      down  = rq.quadrant[QUAD_DOWN_BIT];
      if (rad > MAX_RADIUS) rad = MAX_RADIUS;
      x = 0;
      y = rad;
      d = D_START - 2*rad;
      n = 0;
      while (y >= x && n < RESULT_LIMIT) begin
         sp.coord[SPAN_A_ROW]   = SPAN_W'(down ? cy + y : cy - y);
         sp.coord[SPAN_B_ROW]   = SPAN_W'(down ? cy + x : cy - x);
         sp.coord[SPAN_A_START] = SPAN_W'(right ? cx : cx - x);
         sp.coord[SPAN_A_END]   = SPAN_W'(right ? cx + x : cx);
         sp.coord[SPAN_B_START] = SPAN_W'(right ? cx : cx - y);
         sp.coord[SPAN_B_END]   = SPAN_W'(right ? cx + y : cx);
         if (d < 0) begin
            d = d + 4*x + D_STEP_INNER;
         end else begin
            d = d + 4*(x - y) + D_STEP_OUTER;
            y--;
         end
         x++;
         n++;
         sp.last = (y < x) || (n >= RESULT_LIMIT);
         expected_spans.push_back(sp);
      end
   endfunction

   task automatic add_request(input logic signed [COORD_WIDTH-1:0] cx, cy,
                              input int rad, input quad_code_type quad,
                              input logic drain, calm);
      fill_req_type rq;
      rq.center_x    = cx;
      rq.center_y    = cy;
      rq.radius      = RADIUS_WIDTH'(rad);
      rq.quadrant    = quad;
      rq.drain_first = drain;
      rq.calm_tail   = calm;
      pending_requests.push_back(rq);
   endtask

   task automatic report_mismatch(input string what, input logic [SPAN_W-1:0] want, got);
      if (mismatches < REPORT_LIMIT)
         $display("mismatch on %s: expected %0d, got %0d", what,
                  $signed(want), $signed(got));
      mismatches++;
   endtask

   // Request driver.
   int   req_gap_left  = 0;
   int   req_mode_left = 0;
   logic req_gaps_on   = 1'b1;

   always @(negedge clock) begin
      logic [REQ_W-1:0] data;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 1'b0;
         if (req_mode_left == 0) begin
            req_gaps_on   = 1'($urandom_range(0, 1));
            req_mode_left = $urandom_range(20, 120);
         end else begin
            req_mode_left--;
         end
         if (req_gap_left > 0) begin
            req_gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() == 0 ||
                      (pending_requests[0].drain_first && expected_spans.size() != 0)) begin
            req_tvalid <= 1'b0;
         end else if (!quiet_tail && req_gaps_on && $urandom_range(0, 2) == 0) begin
            req_gap_left = $urandom_range(0, 5);
            req_tvalid <= 1'b0;
         end else begin
            req_item = pending_requests.pop_front();
            if (req_item.calm_tail) quiet_tail = 1'b1;
            data = '0;
            data[COORD_WIDTH-1:0]               = req_item.center_x;
            data[2*COORD_WIDTH-1:COORD_WIDTH]   = req_item.center_y;
            data[2*COORD_WIDTH +: RADIUS_WIDTH] = req_item.radius;
            req_tdata  <= data;
            req_tuser  <= req_item.quadrant;
            req_tvalid <= 1'b1;
         end
      end
   end

   // Result receiver back-pressure.
   int   rsp_stall_left = 0;
   int   rsp_mode_left  = 0;
   logic rsp_stalls_on  = 1'b1;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_mode_left == 0) begin
            rsp_stalls_on = 1'($urandom_range(0, 1));
            rsp_mode_left = $urandom_range(20, 150);
         end else begin
            rsp_mode_left--;
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && rsp_stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_stall_left = $urandom_range(0, 5);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Transfer monitor, checker and watchdog.
   always @(posedge clock) begin
      span_pair_type  want;
      span_field_type fld;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_quadrant_spans(req_item);
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_spans.size() == 0) begin
               if (mismatches < REPORT_LIMIT)
                  $display("unexpected span pair, last %b, data %h", rsp_tlast, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_spans.pop_front();
               for (int k = 0; k < SPAN_FIELDS; k++) begin
                  fld = span_field_type'(k);
                  if (rsp_tdata[k*SPAN_W +: SPAN_W] !== want.coord[k])
                     report_mismatch(fld.name(), want.coord[k],
                                     rsp_tdata[k*SPAN_W +: SPAN_W]);
               end
               if (rsp_tlast !== want.last)
                  report_mismatch("last_span_pair", SPAN_W'(want.last), SPAN_W'(rsp_tlast));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      int rad, pick;
      logic signed [COORD_WIDTH-1:0] cx, cy;

      add_request(16'sd0, 16'sd0, 0, QUAD_LEFT_UP, 1'b0, 1'b0);
      add_request(16'sd100, -16'sd50, 0, QUAD_RIGHT_UP, 1'b0, 1'b0);
      add_request(16'sh7fff, 16'sh8000, 0, QUAD_LEFT_DOWN, 1'b0, 1'b0);
      add_request(16'sh8000, 16'sh7fff, 0, QUAD_RIGHT_DOWN, 1'b0, 1'b0);
      add_request(16'sd10, 16'sd20, 1, QUAD_LEFT_UP, 1'b0, 1'b0);
      add_request(-16'sd10, 16'sd20, 2, QUAD_RIGHT_UP, 1'b0, 1'b0);
      add_request(16'sd1234, -16'sd4321, 3, QUAD_LEFT_DOWN, 1'b0, 1'b0);
      add_request(16'sd0, 16'sd0, 4, QUAD_RIGHT_DOWN, 1'b0, 1'b0);
      add_request(16'sd7, 16'sd9, 5, QUAD_LEFT_UP, 1'b0, 1'b0);
      add_request(16'sh7fff, 16'sh7fff, 85, QUAD_RIGHT_DOWN, 1'b0, 1'b0);
      add_request(16'sh8000, 16'sh8000, 85, QUAD_LEFT_UP, 1'b0, 1'b0);
      add_request(16'sh7fff, 16'sh8000, 85, QUAD_RIGHT_UP, 1'b0, 1'b0);
      add_request(16'sh8000, 16'sh7fff, 85, QUAD_LEFT_DOWN, 1'b0, 1'b0);
      add_request(16'sd300, 16'sd300, 86, QUAD_RIGHT_UP, 1'b0, 1'b0);
      add_request(-16'sd300, 16'sd300, 127, QUAD_LEFT_DOWN, 1'b0, 1'b0);
      add_request(16'sd0, -16'sd1, 100, QUAD_LEFT_UP, 1'b0, 1'b0);
      add_request(16'sd55, 16'sd66, 84, QUAD_RIGHT_DOWN, 1'b0, 1'b0);
      add_request(-16'sd1, 16'sd0, 64, QUAD_LEFT_UP, 1'b0, 1'b0);
      add_request(16'sd32000, -16'sd32000, 63, QUAD_RIGHT_UP, 1'b0, 1'b0);

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         pick = $urandom_range(0, 19);
         if (pick < 3)
            rad = $urandom_range(0, 8);
         else if (pick < 6)
            rad = $urandom_range(MAX_RADIUS + 1, (1 << RADIUS_WIDTH) - 1);
         else
            rad = $urandom_range(0, MAX_RADIUS);
         cx = COORD_WIDTH'($urandom);
         cy = COORD_WIDTH'($urandom);
         if ($urandom_range(0, 15) == 0) cx = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         if ($urandom_range(0, 15) == 0) cy = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         add_request(cx, cy, rad, quad_code_type'($urandom_range(0, 3)),
                     i == 0 || $urandom_range(0, 59) == 0,
                     i >= RANDOM_REQUESTS - CALM_REQUESTS);
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_requests.size() != 0 || req_tvalid) @(negedge clock);
      while (expected_spans.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatches == 0 && expected_spans.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
